[hw/rtl/baro_temp_pressure_compensate_assert.svh]
// assertion macros shared by the compensation block
`ifndef BARO_TEMP_PRESSURE_COMPENSATE_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BTPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("btpc assertion failed");

// next-cycle implication, checked outside reset
`define BTPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("btpc assertion failed");

`endif

[hw/rtl/btpc_pkg.sv]
`timescale 1ns / 1ps
package btpc_pkg;

  localparam int DATA_W = 32;
  localparam int CAL_W  = 16;
  localparam int RAW_W  = 24;

  // register indexes of the configuration port
  localparam logic [2:0] REG_CAL_AC = 3'd0;
  localparam logic [2:0] REG_CAL_AC456 = 3'd1;
  localparam logic [2:0] REG_CAL_B = 3'd2;
  localparam logic [2:0] REG_CAL_M = 3'd3;
  localparam logic [2:0] REG_OSS = 3'd4;

  localparam logic [0:0] OP_TEMP  = 1'b0;
  localparam logic [0:0] OP_PRESS = 1'b1;

  // datasheet constants
  localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
  localparam logic signed [31:0] K_SQ      = 32'sd3038;
  localparam logic signed [31:0] K_LIN     = -32'sd7357;
  localparam logic signed [31:0] K_OFS     = 32'sd3791;
  localparam logic [31:0]        K_B7      = 32'd50000;
  localparam logic [31:0]        K_B4_OFS  = 32'd32768;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_X1,
    ST_T_DEN,
    ST_T_CHK,
    ST_T_DIVGO,
    ST_T_DIVW,
    ST_T_FIN,
    ST_P_B6,
    ST_P_SQ,
    ST_P_X1,
    ST_P_X2,
    ST_P_B3,
    ST_P_X1B,
    ST_P_X2B,
    ST_P_X3,
    ST_P_B4,
    ST_P_B7,
    ST_P_CHK,
    ST_P_DIVGO,
    ST_P_DIVW,
    ST_P_Q,
    ST_P_SQ2,
    ST_P_M1,
    ST_P_M2,
    ST_P_FIN,
    ST_ERR
  } state_t;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic [1:0]         oss;
  } cfg_t;

  typedef struct packed {
    state_t step;
    logic   load_in;
    logic   div_start;
    logic   write_out;
    logic   write_err;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic b4_zero;
    logic div_done;
    logic div_busy;
    logic out_free;
  } status_t;

  // signed divide by 2^k, truncating toward zero
  function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] a,
                                                   input int k);
    logic signed [31:0] bias;
    bias = (32'sd1 <<< k) - 32'sd1;
    if (a[31]) return (a + bias) >>> k;
    else       return a >>> k;
  endfunction

endpackage

[hw/rtl/btpc_stream_if.sv]
`timescale 1ns / 1ps
// input item channel
interface btpc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [23:0] raw_value;
  modport source (output valid, output operation, output raw_value, input ready);
  modport sink (input valid, input operation, input raw_value, output ready);
endinterface

// result item channel
interface btpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               div_error;
  modport source (output valid, output value, output div_error, input ready);
  modport sink (input valid, input value, input div_error, output ready);
endinterface

[hw/rtl/btpc_divider.sv]
`timescale 1ns / 1ps
module btpc_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);
  import btpc_pkg::*;

  logic [32:0] rem;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic [32:0] rem_sh;
  logic [33:0] diff;

  // one restoring step per cycle, borrow taken from an extra bit
  assign rem_sh = {rem[31:0], quotient[31]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath of the divider
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!diff[33]) begin
        rem      <= diff[32:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= rem_sh;
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end

endmodule

[hw/rtl/btpc_datapath.sv]
`timescale 1ns / 1ps
module btpc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  btpc_pkg::cfg_t    cfg,
  input  btpc_pkg::cmd_t    cmd,
  output btpc_pkg::status_t status,
  input  logic [23:0]       raw_value,
  btpc_out_if.source        out_ch
);
  import btpc_pkg::*;

  logic signed [31:0] b5, b6, sq, x1, x2, b3, x3, p, den, up;
  logic [31:0]        b4, b7;
  logic [23:0]        raw;
  logic               neg;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [31:0] prod_lo;
  logic               div_busy, div_done;
  logic [31:0]        div_q, div_a, div_b;
  logic signed [31:0] num, q_s, b5_new, p_new, b3_sum;
  logic [31:0]        q_u;
  logic               out_valid;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = b6;
    mul_b = b6;
    unique case (cmd.step)
      ST_T_X1: begin
        mul_a = $signed({16'd0, raw[15:0]}) - $signed({16'd0, cfg.ac6});
        mul_b = $signed({16'd0, cfg.ac5});
      end
      ST_P_X1:  begin mul_a = 32'(cfg.b2);  mul_b = sq; end
      ST_P_X2:  begin mul_a = 32'(cfg.ac2); mul_b = b6; end
      ST_P_X1B: begin mul_a = 32'(cfg.ac3); mul_b = b6; end
      ST_P_X2B: begin mul_a = 32'(cfg.b1);  mul_b = sq; end
      ST_P_B4: begin
        mul_a = $signed({16'd0, cfg.ac4});
        mul_b = x3 + $signed(K_B4_OFS);
      end
      ST_P_B7: begin
        mul_a = up - b3;
        mul_b = $signed(K_B7 >> cfg.oss);
      end
      ST_P_SQ2: begin mul_a = x1;    mul_b = x1; end
      ST_P_M1:  begin mul_a = x1;    mul_b = K_SQ; end
      ST_P_M2:  begin mul_a = K_LIN; mul_b = p; end
      default:  begin mul_a = b6;    mul_b = b6; end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_lo = prod[31:0];

  // divider operands: signed magnitudes for temperature, unsigned for pressure
  assign num = 32'(cfg.mc) <<< 11;
  always_comb begin
    if (cmd.step == ST_T_DIVGO) begin
      div_a = num[31] ? 32'(-num) : 32'(num);
      div_b = den[31] ? 32'(-den) : 32'(den);
    end else begin
      div_a = b7[31] ? b7 : {b7[30:0], 1'b0};
      div_b = b4;
    end
  end

  btpc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_s    = neg ? $signed(-div_q) : $signed(div_q);
  assign b5_new = x1 + q_s;
  assign q_u    = b7[31] ? {div_q[30:0], 1'b0} : div_q;
  assign p_new  = $signed(q_u);
  assign b3_sum = ((($signed(32'(cfg.ac1)) <<< 2) + x1 + x2) << cfg.oss) + 32'sd2;

  // stored temperature intermediate
  always_ff @(posedge clk) begin
    if (rst) begin
      b5 <= '0;
    end else if (cmd.step == ST_T_FIN) begin
      b5 <= b5_new;
    end
  end

  // working registers, one step per state
  always_ff @(posedge clk) begin
    if (cmd.load_in) raw <= raw_value;
    unique case (cmd.step)
      ST_T_X1:    x1 <= sdiv_pow2(prod_lo, 15);
      ST_T_DEN:   den <= x1 + 32'(cfg.md);
      ST_T_DIVGO: neg <= cfg.mc[15] ^ den[31];
      ST_P_B6: begin
        b6 <= b5 - B6_OFFSET;
        up <= $signed({8'd0, raw} >> (4'd8 - {2'd0, cfg.oss}));
      end
      ST_P_SQ:  sq <= sdiv_pow2(prod_lo, 12);
      ST_P_X1:  x1 <= sdiv_pow2(prod_lo, 11);
      ST_P_X2:  x2 <= sdiv_pow2(prod_lo, 11);
      ST_P_B3:  b3 <= sdiv_pow2(b3_sum, 2);
      ST_P_X1B: x1 <= sdiv_pow2(prod_lo, 13);
      ST_P_X2B: x2 <= sdiv_pow2(prod_lo, 16);
      ST_P_X3:  x3 <= sdiv_pow2(x1 + x2 + 32'sd2, 2);
      ST_P_B4:  b4 <= 32'(prod_lo) >> 15;
      ST_P_B7:  b7 <= prod_lo;
      ST_P_Q: begin
        p  <= p_new;
        x1 <= sdiv_pow2(p_new, 8);
      end
      ST_P_SQ2: x1 <= prod_lo;
      ST_P_M1:  x1 <= sdiv_pow2(prod_lo, 16);
      ST_P_M2:  x2 <= sdiv_pow2(prod_lo, 16);
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      out_ch.div_error <= cmd.write_err;
      if (cmd.write_err) begin
        out_ch.value <= '0;
      end else if (cmd.step == ST_T_FIN) begin
        out_ch.value <= sdiv_pow2(b5_new + 32'sd8, 4);
      end else begin
        out_ch.value <= p + sdiv_pow2(x1 + x2 + K_OFS, 4);
      end
    end
  end

  assign out_ch.valid     = out_valid;
  assign status.den_zero  = (den == '0);
  assign status.b4_zero   = (b4 == '0);
  assign status.div_done  = div_done;
  assign status.div_busy  = div_busy;
  assign status.out_free  = !out_valid || out_ch.ready;

endmodule

[hw/rtl/btpc_ctrl.sv]
`timescale 1ns / 1ps
`include "baro_temp_pressure_compensate_assert.svh"
module btpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  btpc_pkg::status_t status,
  output btpc_pkg::cmd_t    cmd
);
  import btpc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = (in_op == OP_PRESS) ? ST_P_B6 : ST_T_X1;
      ST_T_X1:    state_next = ST_T_DEN;
      ST_T_DEN:   state_next = ST_T_CHK;
      ST_T_CHK:   state_next = status.den_zero ? ST_ERR : ST_T_DIVGO;
      ST_T_DIVGO: state_next = ST_T_DIVW;
      ST_T_DIVW:  if (status.div_done) state_next = ST_T_FIN;
      ST_T_FIN:   if (status.out_free) state_next = ST_IDLE;
      ST_P_B6:    state_next = ST_P_SQ;
      ST_P_SQ:    state_next = ST_P_X1;
      ST_P_X1:    state_next = ST_P_X2;
      ST_P_X2:    state_next = ST_P_B3;
      ST_P_B3:    state_next = ST_P_X1B;
      ST_P_X1B:   state_next = ST_P_X2B;
      ST_P_X2B:   state_next = ST_P_X3;
      ST_P_X3:    state_next = ST_P_B4;
      ST_P_B4:    state_next = ST_P_B7;
      ST_P_B7:    state_next = ST_P_CHK;
      ST_P_CHK:   state_next = status.b4_zero ? ST_ERR : ST_P_DIVGO;
      ST_P_DIVGO: state_next = ST_P_DIVW;
      ST_P_DIVW:  if (status.div_done) state_next = ST_P_Q;
      ST_P_Q:     state_next = ST_P_SQ2;
      ST_P_SQ2:   state_next = ST_P_M1;
      ST_P_M1:    state_next = ST_P_M2;
      ST_P_M2:    state_next = ST_P_FIN;
      ST_P_FIN:   if (status.out_free) state_next = ST_IDLE;
      ST_ERR:     if (status.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd           = '0;
    cmd.step      = state;
    cmd.load_in   = (state == ST_IDLE) && in_valid;
    cmd.div_start = (state == ST_T_DIVGO) || (state == ST_P_DIVGO);
    cmd.write_out = ((state == ST_T_FIN) || (state == ST_P_FIN) || (state == ST_ERR))
                    && status.out_free;
    cmd.write_err = (state == ST_ERR);
  end

  assign in_ready = (state == ST_IDLE);

  `BTPC_ASSERT_IMPL(a_start_idle_div, cmd.div_start, !status.div_busy)
  `BTPC_ASSERT_IMPL(a_done_when_waiting, status.div_done,
                    state == ST_T_DIVW || state == ST_P_DIVW)
  `BTPC_ASSERT_NEXT(a_transfer_leaves_idle, in_valid && in_ready, state != ST_IDLE)

endmodule

[hw/rtl/baro_temp_pressure_compensate.sv]
`timescale 1ns / 1ps
// Barometric temperature and pressure compensation in the datasheet integer
// form. Program the four calibration registers and the oversampling setting
// over the APB port (64-bit registers at byte address 8*i), then send items:
// operation 0 takes a raw temperature and stores B5, operation 1 takes a raw
// 24-bit pressure and uses the last stored B5. One item is worked at a time;
// the next input is taken only once the result has been written to the
// output register, which waits until the sink has taken the previous result.
// The items are stepped by the sequencer through one shared 32x32 multiplier
// and a bit-serial divider. A zero divisor returns 0 with div_error set.
module baro_temp_pressure_compensate (
  input  logic        clk,
  input  logic        rst,
  btpc_in_if.sink     in_ch,
  btpc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import btpc_pkg::*;

  logic [47:0] cal_ac, cal_ac456, cal_b;
  logic [31:0] cal_m;
  logic [1:0]  oss;
  logic        wr_en;
  logic [2:0]  reg_idx;
  cfg_t        cfg;
  cmd_t        cmd;
  status_t     status;
  logic        in_ready;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac    <= '0;
      cal_ac456 <= '0;
      cal_b     <= '0;
      cal_m     <= '0;
      oss       <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CAL_AC:    cal_ac    <= pwdata[47:0];
        REG_CAL_AC456: cal_ac456 <= pwdata[47:0];
        REG_CAL_B:     cal_b     <= pwdata[47:0];
        REG_CAL_M:     cal_m     <= pwdata[31:0];
        REG_OSS:       oss       <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_CAL_AC:    prdata = {16'd0, cal_ac};
      REG_CAL_AC456: prdata = {16'd0, cal_ac456};
      REG_CAL_B:     prdata = {16'd0, cal_b};
      REG_CAL_M:     prdata = {32'd0, cal_m};
      REG_OSS:       prdata = {62'd0, oss};
      default:       prdata = '0;
    endcase
  end

  // unpack calibration words
  assign cfg.ac1 = cal_ac[15:0];
  assign cfg.ac2 = cal_ac[31:16];
  assign cfg.ac3 = cal_ac[47:32];
  assign cfg.ac4 = cal_ac456[15:0];
  assign cfg.ac5 = cal_ac456[31:16];
  assign cfg.ac6 = cal_ac456[47:32];
  assign cfg.b1  = cal_b[15:0];
  assign cfg.b2  = cal_b[31:16];
  assign cfg.mc  = cal_m[15:0];
  assign cfg.md  = cal_m[31:16];
  assign cfg.oss = oss;

  assign in_ch.ready = in_ready;

  btpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  btpc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .raw_value (in_ch.raw_value),
    .out_ch    (out_ch)
  );

endmodule
